@@ hw/rtl/ufd_pkg.sv @@
// Shared types, codes and the CRC-16 byte step for the frame deframer.
// Used by the controller, the datapath and the top level; depends on nothing.
package ufd_pkg;

    localparam logic [1:0] FMT_SUM  = 2'd0;
    localparam logic [1:0] FMT_LEN  = 2'd1;
    localparam logic [1:0] FMT_AA55 = 2'd2;
    localparam logic [1:0] FMT_BAD  = 2'd3;

    localparam logic [7:0] HDR_55 = 8'h55;
    localparam logic [7:0] HDR_AA = 8'hAA;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [1:0] DROP_NONE = 2'd0;
    localparam logic [1:0] DROP_ONE  = 2'd1;
    localparam logic [1:0] DROP_LEN  = 2'd2;
    localparam logic [1:0] DROP_BASE = 2'd3;

    typedef struct packed {
        logic       append;
        logic       rd;
        logic       i_load;
        logic [3:0] i_val;
        logic       i_inc;
        logic       base_clr;
        logic       base_inc;
        logic       cap_b0;
        logic       cap_hi;
        logic       cap_cmd;
        logic       cap_addr;
        logic       len_word;
        logic       len_byte;
        logic       len_eleven;
        logic       sum_load;
        logic       sum_add;
        logic       crc_clr;
        logic       crc_upd;
        logic [1:0] drop;
        logic       push;
        logic       push_empty;
        logic       flush;
    } ufd_cmd_t;

    typedef struct packed {
        logic [7:0] q;
        logic [1:0] fmt;
        logic       cnt_zero;
        logic       cnt_lt2;
        logic       cnt_lt3;
        logic       cnt_lt11;
        logic       cnt_lt_byte;
        logic       cnt_lt_word;
        logic       word_len_ok;
        logic       byte_len_ok;
        logic       cand_ok;
        logic       la_fits;
        logic       sum_match;
        logic       crc_match;
        logic       crc_data;
        logic       crc_hi;
        logic       base_zero;
        logic       i_is_one;
        logic       i_is_ten;
        logic       emit_empty;
        logic       emit_last;
        logic       addr_zero;
        logic       push_ok;
        logic       out_free;
        logic       pend_v;
    } ufd_stat_t;

    function automatic logic [15:0] ufd_crc_byte(input logic [15:0] crc_in,
                                                 input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/uart_frame_sync_crc_deframer_core.sv @@
// One input byte per transaction; the hunt reads the buffer RAM byte by byte,
// checking the frame bytes in turn, and a lookahead resync scan may try each
// later offset in the buffer that still leaves room for a minimal frame.
// A new byte is taken only after the hunt for the previous one has finished.
// Reset clears the fill count and selects format 2; buffer contents stay undefined.
// Top level: joins the hunt controller and the datapath. Depends on ufd_pkg, ufd_ctrl and ufd_dpath.
module uart_frame_sync_crc_deframer_core
    import ufd_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] command,
    output logic [7:0] payload_byte,
    output logic       payload_valid,
    output logic       frame_end,
    output logic       last
);

    ufd_cmd_t  cmd;
    ufd_stat_t stat;

    ufd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ufd_dpath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_byte       (rx_byte),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .command       (command),
        .payload_byte  (payload_byte),
        .payload_valid (payload_valid),
        .frame_end     (frame_end),
        .last          (last)
    );

endmodule

@@ hw/rtl/ufd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ufd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/ufd_ctrl.sv @@
// Hunt controller of the frame deframer: walks the frame checks byte by byte.
// Depends on ufd_pkg; drives the datapath through ufd_cmd_t, reads ufd_stat_t.
module ufd_ctrl
    import ufd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ufd_stat_t stat,
    output ufd_cmd_t  cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_HUNT  = 5'd1;
    localparam logic [4:0] S_B0    = 5'd2;
    localparam logic [4:0] S_SUM   = 5'd3;
    localparam logic [4:0] S_B1    = 5'd4;
    localparam logic [4:0] S_L2    = 5'd5;
    localparam logic [4:0] S_W0    = 5'd6;
    localparam logic [4:0] S_W1    = 5'd7;
    localparam logic [4:0] S_LA    = 5'd8;
    localparam logic [4:0] S_LA0   = 5'd9;
    localparam logic [4:0] S_LA1   = 5'd10;
    localparam logic [4:0] S_CRC   = 5'd11;
    localparam logic [4:0] S_CMD1  = 5'd12;
    localparam logic [4:0] S_ADDR  = 5'd13;
    localparam logic [4:0] S_CMD2  = 5'd14;
    localparam logic [4:0] S_EMS   = 5'd15;
    localparam logic [4:0] S_EM    = 5'd16;
    localparam logic [4:0] S_EMPTY = 5'd17;
    localparam logic [4:0] S_FLUSH = 5'd18;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.append = 1'b1;
                    state_next = S_HUNT;
                end
            end
            S_HUNT:
            begin
                if (stat.cnt_zero)
                    state_next = S_FLUSH;
                else if (stat.fmt == FMT_LEN && stat.cnt_lt2)
                    state_next = S_FLUSH;
                else
                begin
                    cmd.base_clr = 1'b1;
                    cmd.i_load   = 1'b1;
                    cmd.i_val    = 4'd0;
                    cmd.rd       = 1'b1;
                    state_next   = (stat.fmt == FMT_LEN) ? S_W0 : S_B0;
                end
            end
            S_B0:
            begin
                if (stat.fmt == FMT_SUM)
                begin
                    if (stat.q != HDR_55)
                    begin
                        cmd.drop   = DROP_ONE;
                        state_next = S_HUNT;
                    end
                    else if (stat.cnt_lt11)
                        state_next = S_FLUSH;
                    else
                    begin
                        cmd.sum_load = 1'b1;
                        cmd.i_inc    = 1'b1;
                        cmd.rd       = 1'b1;
                        state_next   = S_SUM;
                    end
                end
                else
                begin
                    if (stat.q != HDR_AA)
                    begin
                        cmd.drop   = DROP_ONE;
                        state_next = S_HUNT;
                    end
                    else if (stat.cnt_lt2)
                        state_next = S_FLUSH;
                    else
                    begin
                        cmd.i_inc  = 1'b1;
                        cmd.rd     = 1'b1;
                        state_next = S_B1;
                    end
                end
            end
            S_SUM:
            begin
                if (stat.i_is_ten)
                begin
                    if (!stat.sum_match)
                    begin
                        cmd.drop   = DROP_ONE;
                        state_next = S_HUNT;
                    end
                    else
                    begin
                        cmd.len_eleven = 1'b1;
                        cmd.i_load     = 1'b1;
                        cmd.i_val      = 4'd2;
                        state_next     = S_EMS;
                    end
                end
                else
                begin
                    cmd.cap_cmd = stat.i_is_one;
                    cmd.sum_add = 1'b1;
                    cmd.i_inc   = 1'b1;
                    cmd.rd      = 1'b1;
                end
            end
            S_B1:
            begin
                if (stat.q != HDR_55)
                begin
                    cmd.drop   = DROP_ONE;
                    state_next = S_HUNT;
                end
                else if (stat.cnt_lt3)
                    state_next = S_FLUSH;
                else
                begin
                    cmd.i_inc  = 1'b1;
                    cmd.rd     = 1'b1;
                    state_next = S_L2;
                end
            end
            S_L2:
            begin
                cmd.len_byte = 1'b1;
                if (!stat.byte_len_ok)
                begin
                    cmd.drop   = DROP_ONE;
                    state_next = S_HUNT;
                end
                else if (stat.cnt_lt_byte)
                    state_next = S_FLUSH;
                else
                begin
                    cmd.crc_clr = 1'b1;
                    cmd.i_load  = 1'b1;
                    cmd.i_val   = 4'd0;
                    cmd.rd      = 1'b1;
                    state_next  = S_CRC;
                end
            end
            S_W0:
            begin
                cmd.cap_b0 = 1'b1;
                cmd.i_inc  = 1'b1;
                cmd.rd     = 1'b1;
                state_next = S_W1;
            end
            S_W1:
            begin
                cmd.len_word = 1'b1;
                if (!stat.word_len_ok)
                begin
                    cmd.drop   = DROP_ONE;
                    state_next = S_HUNT;
                end
                else if (stat.cnt_lt_word)
                begin
                    // Front frame is incomplete: scan later offsets for a good frame.
                    cmd.base_inc = 1'b1;
                    state_next   = S_LA;
                end
                else
                begin
                    cmd.crc_clr = 1'b1;
                    cmd.i_load  = 1'b1;
                    cmd.i_val   = 4'd0;
                    cmd.rd      = 1'b1;
                    state_next  = S_CRC;
                end
            end
            S_LA:
            begin
                if (!stat.la_fits)
                    state_next = S_FLUSH;
                else
                begin
                    cmd.i_load = 1'b1;
                    cmd.i_val  = 4'd0;
                    cmd.rd     = 1'b1;
                    state_next = S_LA0;
                end
            end
            S_LA0:
            begin
                cmd.cap_b0 = 1'b1;
                cmd.i_inc  = 1'b1;
                cmd.rd     = 1'b1;
                state_next = S_LA1;
            end
            S_LA1:
            begin
                cmd.len_word = 1'b1;
                if (stat.cand_ok)
                begin
                    cmd.crc_clr = 1'b1;
                    cmd.i_load  = 1'b1;
                    cmd.i_val   = 4'd0;
                    cmd.rd      = 1'b1;
                    state_next  = S_CRC;
                end
                else
                begin
                    cmd.base_inc = 1'b1;
                    state_next   = S_LA;
                end
            end
            S_CRC:
            begin
                if (stat.crc_data)
                begin
                    cmd.crc_upd = 1'b1;
                    cmd.i_inc   = 1'b1;
                    cmd.rd      = 1'b1;
                end
                else if (stat.crc_hi)
                begin
                    cmd.cap_hi = 1'b1;
                    cmd.i_inc  = 1'b1;
                    cmd.rd     = 1'b1;
                end
                else if (!stat.base_zero)
                begin
                    if (stat.crc_match)
                    begin
                        cmd.drop   = DROP_BASE;
                        state_next = S_HUNT;
                    end
                    else
                    begin
                        cmd.base_inc = 1'b1;
                        state_next   = S_LA;
                    end
                end
                else if (!stat.crc_match)
                begin
                    cmd.drop   = DROP_ONE;
                    state_next = S_HUNT;
                end
                else
                begin
                    cmd.i_load = 1'b1;
                    cmd.rd     = 1'b1;
                    cmd.i_val  = (stat.fmt == FMT_LEN) ? 4'd2 : 4'd3;
                    state_next = (stat.fmt == FMT_LEN) ? S_CMD1 : S_ADDR;
                end
            end
            S_CMD1:
            begin
                cmd.cap_cmd = 1'b1;
                cmd.i_inc   = 1'b1;
                state_next  = S_EMS;
            end
            S_ADDR:
            begin
                cmd.cap_addr = 1'b1;
                cmd.i_inc    = 1'b1;
                cmd.rd       = 1'b1;
                state_next   = S_CMD2;
            end
            S_CMD2:
            begin
                cmd.cap_cmd = 1'b1;
                if (!stat.addr_zero)
                begin
                    // Good frame for another address: removed with no result.
                    cmd.drop   = DROP_LEN;
                    state_next = S_HUNT;
                end
                else
                begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_EMS;
                end
            end
            S_EMS:
            begin
                if (stat.fmt != FMT_SUM && stat.emit_empty)
                    state_next = S_EMPTY;
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_EM;
                end
            end
            S_EM:
            begin
                if (stat.push_ok)
                begin
                    cmd.push = 1'b1;
                    if (stat.emit_last)
                    begin
                        cmd.drop   = DROP_LEN;
                        state_next = S_HUNT;
                    end
                    else
                    begin
                        cmd.i_inc = 1'b1;
                        cmd.rd    = 1'b1;
                    end
                end
            end
            S_EMPTY:
            begin
                if (stat.push_ok)
                begin
                    cmd.push       = 1'b1;
                    cmd.push_empty = 1'b1;
                    cmd.drop       = DROP_LEN;
                    state_next     = S_HUNT;
                end
            end
            S_FLUSH:
            begin
                if (!stat.pend_v)
                    state_next = S_IDLE;
                else if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/ufd_dpath.sv @@
// Datapath of the frame deframer: circular byte buffer, pointers, checks and
// the result registers. Depends on ufd_pkg and ufd_ram.
module ufd_dpath
    import ufd_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] rx_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data,
    input  ufd_cmd_t   cmd,
    output ufd_stat_t  stat,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] command,
    output logic [7:0] payload_byte,
    output logic       payload_valid,
    output logic       frame_end,
    output logic       last
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(BUFFER_DEPTH);

    function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
        logic [AW:0] r;
        r = (v >= DEPTH_W) ? (v - DEPTH_W) : v;
        return r[AW-1:0];
    endfunction

    logic [1:0]    fmt_reg;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] base_reg, base_next;
    logic [CW-1:0] len_reg;
    logic [7:0]    b0_reg, hi_reg, cmd_reg, addr_reg, sum_reg;
    logic [15:0]   crc_reg;
    logic [7:0]    q;
    logic [15:0]   word;
    logic [CW:0]   lidx;
    logic [AW-1:0] raddr, waddr;
    logic [CW-1:0] drop_n;
    logic          full;

    logic       pend_v_reg;
    logic [7:0] pend_cmd_reg, pend_pb_reg;
    logic       pend_pv_reg, pend_fe_reg;
    logic       out_v_reg;
    logic [7:0] out_cmd_reg, out_pb_reg;
    logic       out_pv_reg, out_fe_reg, out_last_reg;
    logic       move;
    logic       out_free;

    assign cfg_ready = 1'b1;
    assign word      = {b0_reg, q};
    assign full      = (cnt_reg == CW'(BUFFER_DEPTH));

    // Read address is formed from next-state index values, so a command can
    // step the index and read the new position in the same cycle.
    assign lidx  = {1'b0, base_next} + {1'b0, i_next};
    assign raddr = wrap({1'b0, head_reg} + (AW + 1)'(lidx));
    assign waddr = full ? head_reg : wrap({1'b0, head_reg} + (AW + 1)'(cnt_reg));

    ufd_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.append),
        .waddr (waddr),
        .wdata (rx_byte),
        .re    (cmd.rd),
        .raddr (raddr),
        .rdata (q)
    );

    always_comb
    begin
        i_next = i_reg;
        if (cmd.i_load)
            i_next = CW'(cmd.i_val);
        else if (cmd.i_inc)
            i_next = i_reg + 1'b1;

        base_next = base_reg;
        if (cmd.base_clr)
            base_next = '0;
        else if (cmd.base_inc)
            base_next = base_reg + 1'b1;

        unique case (cmd.drop)
            DROP_ONE:  drop_n = CW'(1);
            DROP_LEN:  drop_n = len_reg;
            DROP_BASE: drop_n = base_reg;
            default:   drop_n = '0;
        endcase

        head_next = head_reg;
        cnt_next  = cnt_reg;
        if (cmd.append)
        begin
            if (full)
                head_next = wrap({1'b0, head_reg} + (AW + 1)'(1));
            else
                cnt_next = cnt_reg + 1'b1;
        end
        else if (cmd.drop != DROP_NONE)
        begin
            head_next = wrap({1'b0, head_reg} + (AW + 1)'(drop_n));
            cnt_next  = cnt_reg - drop_n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg  <= FMT_AA55;
            head_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_data != FMT_BAD)
                fmt_reg <= cfg_data;
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        base_reg <= base_next;
        if (cmd.len_word)
            len_reg <= word[CW-1:0];
        else if (cmd.len_byte)
            len_reg <= q[CW-1:0];
        else if (cmd.len_eleven)
            len_reg <= CW'(11);
        if (cmd.cap_b0)
            b0_reg <= q;
        if (cmd.cap_hi)
            hi_reg <= q;
        if (cmd.cap_cmd)
            cmd_reg <= q;
        if (cmd.cap_addr)
            addr_reg <= q;
        if (cmd.sum_load)
            sum_reg <= q;
        else if (cmd.sum_add)
            sum_reg <= sum_reg + q;
        if (cmd.crc_clr)
            crc_reg <= '0;
        else if (cmd.crc_upd)
            crc_reg <= ufd_crc_byte(crc_reg, q);
    end

    // Results go through a pending stage: whether a result is the last one of
    // an input byte is known only when the next result or the end arrives.
    assign out_free = !out_v_reg || out_ready;
    assign move     = (cmd.push && pend_v_reg) || cmd.flush;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.push)
                pend_v_reg <= 1'b1;
            else if (cmd.flush)
                pend_v_reg <= 1'b0;
            if (move)
                out_v_reg <= 1'b1;
            else if (out_ready)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_cmd_reg  <= pend_cmd_reg;
            out_pb_reg   <= pend_pb_reg;
            out_pv_reg   <= pend_pv_reg;
            out_fe_reg   <= pend_fe_reg;
            out_last_reg <= cmd.flush;
        end
        if (cmd.push)
        begin
            pend_cmd_reg <= cmd_reg;
            pend_pb_reg  <= cmd.push_empty ? 8'h00 : q;
            pend_pv_reg  <= !cmd.push_empty;
            pend_fe_reg  <= cmd.push_empty ? 1'b1 : stat.emit_last;
        end
    end

    assign out_valid     = out_v_reg;
    assign command       = out_cmd_reg;
    assign payload_byte  = out_pb_reg;
    assign payload_valid = out_pv_reg;
    assign frame_end     = out_fe_reg;
    assign last          = out_last_reg;

    always_comb
    begin
        stat             = '0;
        stat.q           = q;
        stat.fmt         = fmt_reg;
        stat.cnt_zero    = (cnt_reg == '0);
        stat.cnt_lt2     = ({1'b0, cnt_reg} < (CW + 1)'(2));
        stat.cnt_lt3     = ({1'b0, cnt_reg} < (CW + 1)'(3));
        stat.cnt_lt11    = ({1'b0, cnt_reg} < (CW + 1)'(11));
        stat.cnt_lt_byte = (16'(cnt_reg) < 16'(q));
        stat.cnt_lt_word = (16'(cnt_reg) < word);
        stat.word_len_ok = (word >= 16'd5) && (word <= 16'(BUFFER_DEPTH));
        stat.byte_len_ok = (q >= 8'd7) && (16'(q) <= 16'(BUFFER_DEPTH));
        stat.cand_ok     = (word >= 16'd5) && (word <= 16'(cnt_reg - base_reg));
        stat.la_fits     = (({1'b0, base_reg} + (CW + 1)'(5)) <= {1'b0, cnt_reg});
        stat.sum_match   = (sum_reg == q);
        stat.crc_match   = (crc_reg == {hi_reg, q});
        stat.crc_data    = (({1'b0, i_reg} + (CW + 1)'(2)) < {1'b0, len_reg});
        stat.crc_hi      = (({1'b0, i_reg} + (CW + 1)'(2)) == {1'b0, len_reg});
        stat.base_zero   = (base_reg == '0);
        stat.i_is_one    = (i_reg == CW'(1));
        stat.i_is_ten    = (i_reg == CW'(10));
        stat.emit_empty  = (({1'b0, i_reg} + (CW + 1)'(2)) == {1'b0, len_reg});
        if (fmt_reg == FMT_SUM)
            stat.emit_last = (({1'b0, i_reg} + (CW + 1)'(2)) == {1'b0, len_reg});
        else
            stat.emit_last = (({1'b0, i_reg} + (CW + 1)'(3)) == {1'b0, len_reg});
        stat.addr_zero   = (addr_reg == 8'h00);
        stat.out_free    = out_free;
        stat.push_ok     = !pend_v_reg || out_free;
        stat.pend_v      = pend_v_reg;
    end

endmodule

@@ hw/rtl/ufd_checker.sv @@
// Port-level checks for the frame deframer, bound to the top level.
// Depends only on the top level's ports.
module ufd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] command,
    input logic [7:0] payload_byte,
    input logic       payload_valid,
    input logic       frame_end,
    input logic       last
);

    // A stalled result transaction keeps its valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    // A result's command and payload byte stay put while stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(command) && $stable(payload_byte))
        else $error("result changed while stalled");

    // An empty-payload result ends its frame and carries a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !payload_valid |-> frame_end && payload_byte == 8'h00)
        else $error("bad empty-payload result");

    // Only whole frames come out of one input byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> frame_end)
        else $error("last result does not end a frame");

endmodule

bind uart_frame_sync_crc_deframer_core ufd_checker u_ufd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .command       (command),
    .payload_byte  (payload_byte),
    .payload_valid (payload_valid),
    .frame_end     (frame_end),
    .last          (last)
);

@@ verif/uart_frame_sync_crc_deframer_core_tb.sv @@
// Self-checking testbench for the UART frame deframer core in all three frame formats.
// It predicts each frame result itself and feeds random bursts of frames and noise.
// Depends on ufd_pkg and the uart_frame_sync_crc_deframer_core RTL.
`timescale 1ns / 1ps

module uart_frame_sync_crc_deframer_core_tb;
    import ufd_pkg::*;

    localparam int DEPTH = 64;
    localparam int SETTLE_CYCLES = 5000;
    localparam int IDLE_LIMIT = 100000;

    typedef struct {
        logic [7:0] cmd;
        logic [7:0] data;
        logic       data_ok;
        logic       fend;
        logic       lst;
    } frame_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = 8'd0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_data = FMT_AA55;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] command;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       frame_end;
    logic       last;

    logic [7:0]    byte_fifo[$];
    frame_result_t expected_frames[$];

    // Predicted deframer state.
    logic [7:0] rx_buf [DEPTH];
    int         rx_count;
    logic [1:0] cur_format;

    int  mismatch_count = 0;
    int  idle_cycles = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  stall_mode = 0;
    int  stall_timer = 0;
    int  hold_left = 0;
    bit  hold_trigger = 1'b0;
    bit  hold_taken = 1'b0;

    uart_frame_sync_crc_deframer_core #(.BUFFER_DEPTH(DEPTH)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .command(command), .payload_byte(payload_byte), .payload_valid(payload_valid),
        .frame_end(frame_end), .last(last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------- predictor ----------------
    function automatic void buf_drop(input int n);
        if (n >= rx_count)
        begin
            rx_count = 0;
            return;
        end
        for (int i = 0; i < rx_count - n; i++)
            rx_buf[i] = rx_buf[i + n];
        rx_count -= n;
    endfunction

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        c = crc ^ {d, 8'h00};
        for (int b = 0; b < 8; b++)
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        return c;
    endfunction

    function automatic bit buf_crc_good(input int start, input int flen);
        logic [15:0] crc;
        crc = 16'h0000;
        if (flen < 2 || start + flen > DEPTH)
            return 1'b0;
        for (int i = 0; i < flen - 2; i++)
            crc = crc_step(crc, rx_buf[start + i]);
        return crc == {rx_buf[start + flen - 2], rx_buf[start + flen - 1]};
    endfunction

    function automatic void emit_frame(ref frame_result_t res[$], input logic [7:0] cmd,
                                       input int start, input int plen);
        frame_result_t r;
        r.cmd = cmd;
        r.lst = 1'b0;
        if (plen == 0)
        begin
            r.data = 8'd0;
            r.data_ok = 1'b0;
            r.fend = 1'b1;
            res.push_back(r);
            return;
        end
        for (int i = 0; i < plen && start + i < DEPTH; i++)
        begin
            r.data = rx_buf[start + i];
            r.data_ok = 1'b1;
            r.fend = (i + 1 == plen);
            res.push_back(r);
        end
    endfunction

    // One pass of the frame hunt; returns 1 when the front frame is incomplete.
    function automatic bit hunt_pass(ref frame_result_t res[$]);
        int         flen;
        int         cand;
        logic [7:0] sum;
        if (cur_format == FMT_SUM)
        begin
            if (rx_buf[0] != HDR_55) begin buf_drop(1); return 1'b0; end
            if (rx_count < 11) return 1'b1;
            sum = 8'd0;
            for (int i = 0; i < 10; i++)
                sum += rx_buf[i];
            if (sum != rx_buf[10]) begin buf_drop(1); return 1'b0; end
            emit_frame(res, rx_buf[1], 2, 8);
            buf_drop(11);
            return 1'b0;
        end
        if (cur_format == FMT_LEN)
        begin
            if (rx_count < 2) return 1'b1;
            flen = {rx_buf[0], rx_buf[1]};
            if (flen < 5 || flen > DEPTH) begin buf_drop(1); return 1'b0; end
            if (rx_count < flen)
            begin
                // Resync to a later complete frame whose CRC checks out.
                for (int off = 1; off + 5 <= rx_count; off++)
                begin
                    cand = {rx_buf[off], rx_buf[off + 1]};
                    if (cand >= 5 && cand <= rx_count - off && buf_crc_good(off, cand))
                    begin
                        buf_drop(off);
                        return 1'b0;
                    end
                end
                return 1'b1;
            end
            if (!buf_crc_good(0, flen)) begin buf_drop(1); return 1'b0; end
            emit_frame(res, rx_buf[2], 3, flen - 5);
            buf_drop(flen);
            return 1'b0;
        end
        if (rx_buf[0] != HDR_AA) begin buf_drop(1); return 1'b0; end
        if (rx_count < 2) return 1'b1;
        if (rx_buf[1] != HDR_55) begin buf_drop(1); return 1'b0; end
        if (rx_count < 3) return 1'b1;
        flen = rx_buf[2];
        if (flen < 7 || flen > DEPTH) begin buf_drop(1); return 1'b0; end
        if (rx_count < flen) return 1'b1;
        if (!buf_crc_good(0, flen)) begin buf_drop(1); return 1'b0; end
        if (rx_buf[3] == 8'd0)
            emit_frame(res, rx_buf[4], 5, flen - 7);
        buf_drop(flen);
        return 1'b0;
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        frame_result_t res[$];
        if (rx_count >= DEPTH)
            buf_drop(1);
        rx_buf[rx_count] = b;
        rx_count++;
        while (rx_count != 0)
            if (hunt_pass(res))
                break;
        if (res.size() > DEPTH)
            res = res[0:DEPTH-1];
        if (res.size() > 0)
            res[res.size() - 1].lst = 1'b1;
        foreach (res[i])
            expected_frames.push_back(res[i]);
    endfunction

    // ---------------- stimulus building ----------------
    task automatic queue_frame(input logic [1:0] fmt, input int flen, input bit corrupt,
                               input bit truncate);
        logic [7:0]  f[$];
        logic [15:0] crc;
        logic [15:0] lw;
        int          pos;
        crc = 16'h0000;
        lw = 16'(flen);
        if (fmt == FMT_SUM)
        begin
            f = {HDR_55, 8'($urandom)};
            for (int i = 0; i < 8; i++)
                f.push_back(8'($urandom));
            f.push_back(8'd0);
            for (int i = 0; i < 10; i++)
                f[10] += f[i];
        end
        else
        begin
            if (fmt == FMT_LEN)
                f = {lw[15:8], lw[7:0], 8'($urandom)};
            else
                f = {HDR_AA, HDR_55, lw[7:0],
                     ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'd0,
                     8'($urandom)};
            while (f.size() < flen - 2)
                f.push_back(8'($urandom));
            foreach (f[i])
                crc = crc_step(crc, f[i]);
            f.push_back(crc[15:8]);
            f.push_back(crc[7:0]);
        end
        if (corrupt)
        begin
            pos = $urandom_range(0, f.size() - 1);
            f[pos] ^= 8'(1 << $urandom_range(0, 7));
        end
        if (truncate)
            f = f[0:$urandom_range(1, f.size() - 2)];
        foreach (f[i])
            byte_fifo.push_back(f[i]);
    endtask

    task automatic queue_random(input logic [1:0] fmt, input int n_bytes);
        int start_size;
        int pick;
        int min_len;
        int flen;
        start_size = byte_fifo.size();
        min_len = (fmt == FMT_LEN) ? 5 : 7;
        while (byte_fifo.size() - start_size < n_bytes)
        begin
            pick = $urandom_range(0, 9);
            flen = ($urandom_range(0, 11) == 0) ? $urandom_range(min_len, DEPTH)
                                                : $urandom_range(min_len, min_len + 10);
            if (pick == 0)
                repeat ($urandom_range(1, 3)) byte_fifo.push_back(8'($urandom));
            else if (pick == 1)
                queue_frame(fmt, flen, 1'b1, 1'b0);
            else if (pick == 2)
                queue_frame(fmt, flen, 1'b0, 1'b1);
            else
                queue_frame(fmt, flen, 1'b0, 1'b0);
        end
    endtask

    // Waits until every queued byte and every predicted result has gone through.
    task automatic wait_idle();
        while (byte_fifo.size() != 0 || in_valid || expected_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_format(input logic [1:0] v);
        @(posedge clk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // ---------------- driver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && !in_ready))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (byte_fifo.size() > 0)
            begin
                rx_byte <= byte_fifo.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ---------------- receiver stalls ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_trigger && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left <= 3000;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (stall_timer == 0)
            begin
                stall_timer <= $urandom_range(50, 400);
                stall_mode <= $urandom_range(0, 2);
            end
            else
                stall_timer <= stall_timer - 1;
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom);
                default: out_ready <= (stall_timer % 4 == 0);
            endcase
        end
    end

    // ---------------- monitor and checker ----------------
    always @(posedge clk)
    begin
        frame_result_t exp_r;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready && cfg_data != FMT_BAD)
                cur_format = cfg_data;
            if (in_valid && in_ready)
                predict_byte(rx_byte);
            if (out_valid && out_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: cmd %h data %h dv %b end %b last %b",
                                 command, payload_byte, payload_valid, frame_end, last);
                end
                else
                begin
                    exp_r = expected_frames.pop_front();
                    if (command !== exp_r.cmd || payload_byte !== exp_r.data ||
                        payload_valid !== exp_r.data_ok || frame_end !== exp_r.fend ||
                        last !== exp_r.lst)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp cmd %h data %h dv %b end %b last %b, %s",
                                     exp_r.cmd, exp_r.data, exp_r.data_ok, exp_r.fend,
                                     exp_r.lst, $sformatf("got cmd %h data %h dv %b end %b last %b",
                                     command, payload_byte, payload_valid, frame_end, last));
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("uart_frame_sync_crc_deframer_core verification failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- test sequence ----------------
    initial
    begin
        rx_count = 0;
        cur_format = FMT_AA55;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte extremes, empty payload, corrupted frame, too-short length.
        byte_fifo = {8'h00, 8'hFF, HDR_AA, 8'hFF};
        queue_frame(FMT_AA55, 7, 1'b0, 1'b0);
        queue_frame(FMT_AA55, 9, 1'b1, 1'b0);
        byte_fifo.push_back(HDR_AA);
        byte_fifo.push_back(HDR_55);
        byte_fifo.push_back(8'd0);
        byte_fifo.push_back(8'd0);
        wait_idle();

        // Pressure: random frames and noise while the receiver holds off.
        hold_trigger = 1'b1;
        queue_random(FMT_AA55, 15);
        wait_idle();

        write_format(FMT_SUM);
        queue_frame(FMT_SUM, 11, 1'b0, 1'b0);
        queue_random(FMT_SUM, 12);
        wait_idle();

        // A reserved format value leaves the sum format selected.
        write_format(FMT_BAD);
        queue_random(FMT_SUM, 8);
        wait_idle();

        write_format(FMT_LEN);
        queue_frame(FMT_LEN, 5, 1'b0, 1'b0);
        queue_frame(FMT_LEN, DEPTH, 1'b0, 1'b0);
        queue_frame(FMT_LEN, 20, 1'b0, 1'b1);
        queue_frame(FMT_LEN, 8, 1'b0, 1'b0);
        queue_random(FMT_LEN, 12);
        wait_idle();

        // Leftover bytes carry over into the new format.
        write_format(FMT_AA55);
        byte_fifo.push_back(HDR_AA);
        queue_frame(FMT_AA55, DEPTH, 1'b0, 1'b0);
        queue_random(FMT_AA55, 8);
        wait_idle();

        write_format(FMT_LEN);
        queue_random(FMT_LEN, 8);
        wait_idle();

        if (mismatch_count == 0 && expected_frames.size() == 0)
            $display("uart_frame_sync_crc_deframer_core verification clean");
        else
            $display("uart_frame_sync_crc_deframer_core verification failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ufd_pkg.sv
hw/rtl/ufd_ram.sv
hw/rtl/ufd_ctrl.sv
hw/rtl/ufd_dpath.sv
hw/rtl/uart_frame_sync_crc_deframer_core.sv
hw/rtl/ufd_checker.sv
verif/uart_frame_sync_crc_deframer_core_tb.sv
